>>> src/prc_pkg.sv
// prc_pkg: widths, payload structs and register indexes of the PID rate controller
// used by every module under src; depends on nothing

`default_nettype none

package prc_pkg;

   // fixed point rescale of every gain product
   localparam int FRAC_BITS = 4;

   // field and state widths
   localparam int DATA_W   = 16;
   localparam int GAIN_W   = 16;
   localparam int ERR_W    = DATA_W + 1;
   localparam int DERR_W   = ERR_W + 1;
   localparam int INTEG_W  = GAIN_W + 2;
   localparam int DRIVE_W  = GAIN_W + 1;

   // product and rescaled widths
   localparam int PPROD_W  = GAIN_W + 1 + ERR_W;
   localparam int DPROD_W  = GAIN_W + 1 + DERR_W;
   localparam int PRES_W   = PPROD_W - FRAC_BITS;
   localparam int DRES_W   = DPROD_W - FRAC_BITS;

   // sums before clamping, exact over the whole range
   localparam int ISUM_W   = PRES_W + 1;
   localparam int DSUM_W   = DRES_W + 2;

   // stream widths
   localparam int REQ_DATA_W = 2 * DATA_W;
   localparam int RSP_DATA_W = ((DRIVE_W + 7) / 8) * 8;

   // register port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_P_GAIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_I_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_D_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_OUTPUT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_INTEGRAL = 3'd4;

   // reset values of the registers
   localparam logic [GAIN_W-1:0] RST_P_GAIN       = 16'd4800;
   localparam logic [GAIN_W-1:0] RST_I_GAIN       = 16'd19200;
   localparam logic [GAIN_W-1:0] RST_D_GAIN       = 16'd300;
   localparam logic [GAIN_W-1:0] RST_MAX_OUTPUT   = 16'd6400;
   localparam logic [GAIN_W-1:0] RST_MAX_INTEGRAL = 16'd6400;

   typedef struct packed {
      logic [GAIN_W-1:0] p_gain;
      logic [GAIN_W-1:0] i_gain;
      logic [GAIN_W-1:0] d_gain;
      logic [GAIN_W-1:0] max_output;
      logic [GAIN_W-1:0] max_integral;
   } cfg_type;

   // error stage to product stage
   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [DERR_W-1:0] derr;
   } err_type;

   // product stage to accumulate stage, already rescaled
   typedef struct packed {
      logic signed [PRES_W-1:0] p_term;
      logic signed [PRES_W-1:0] i_term;
      logic signed [DRES_W-1:0] d_term;
   } term_type;

endpackage

`default_nettype wire

>>> src/prc_front.sv
// prc_front: input register, error and error change, previous error state
// depends on prc_pkg

`default_nettype none

module prc_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [prc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output prc_pkg::err_type                        out_data
);

   logic                                 valid_ff;
   logic                                 accept;
   logic signed [prc_pkg::ERR_W-1:0]     last_err_ff;
   logic signed [prc_pkg::ERR_W-1:0]     err_in;
   logic signed [prc_pkg::DATA_W-1:0]    measured;
   logic signed [prc_pkg::DATA_W-1:0]    target;
   prc_pkg::err_type                     data_ff;
   prc_pkg::err_type                     data_in;

   // stage can take an item when empty or when its item moves on
   assign req_tready = !valid_ff || out_ready;
   assign accept     = req_tvalid && req_tready;

   // error is measured minus target, change is against the previous item
   always_comb begin
      measured     = $signed(req_tdata[prc_pkg::DATA_W-1:0]);
      target       = $signed(req_tdata[prc_pkg::REQ_DATA_W-1:prc_pkg::DATA_W]);
      err_in       = prc_pkg::ERR_W'(measured) - prc_pkg::ERR_W'(target);
      data_in.err  = err_in;
      data_in.derr = prc_pkg::DERR_W'(err_in) - prc_pkg::DERR_W'(last_err_ff);
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         last_err_ff <= '0;
      end else begin
         if (req_tready) begin
            valid_ff <= req_tvalid;
         end
         if (accept) begin
            last_err_ff <= err_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // the previous error follows each accepted item
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (last_err_ff == $past(err_in)))
      else $error("previous error not updated by item");

endmodule

`default_nettype wire

>>> src/prc_mult.sv
// prc_mult: the three gain products, each floored by FRAC_BITS and registered
// depends on prc_pkg

`default_nettype none

module prc_mult (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire prc_pkg::cfg_type    cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire prc_pkg::err_type    in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output prc_pkg::term_type        out_data
);

   logic                                 valid_ff;
   logic                                 accept;
   logic signed [prc_pkg::PPROD_W-1:0]   p_prod;
   logic signed [prc_pkg::PPROD_W-1:0]   i_prod;
   logic signed [prc_pkg::DPROD_W-1:0]   d_prod;
   prc_pkg::term_type                    data_ff;
   prc_pkg::term_type                    data_in;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // gains are unsigned, a zero top bit makes them signed operands
   always_comb begin
      p_prod = $signed({1'b0, cfg.p_gain}) * in_data.err;
      i_prod = $signed({1'b0, cfg.i_gain}) * in_data.err;
      d_prod = $signed({1'b0, cfg.d_gain}) * in_data.derr;
      // dropping the low bits of a two's complement value floors it
      data_in.p_term = $signed(p_prod[prc_pkg::PPROD_W-1:prc_pkg::FRAC_BITS]);
      data_in.i_term = $signed(i_prod[prc_pkg::PPROD_W-1:prc_pkg::FRAC_BITS]);
      data_in.d_term = $signed(d_prod[prc_pkg::DPROD_W-1:prc_pkg::FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // an accepted item is always held in the stage on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid)
      else $error("product stage lost an item");

endmodule

`default_nettype wire

>>> src/prc_accum.sv
// prc_accum: integral update with clamp, output sum with saturation, result register
// depends on prc_pkg

`default_nettype none

module prc_accum (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire prc_pkg::cfg_type                   cfg,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire prc_pkg::term_type                  in_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [prc_pkg::DRIVE_W-1:0]      rsp_drive,
   output logic                                    rsp_saturated
);

   logic                                 valid_ff;
   logic                                 accept;
   logic signed [prc_pkg::INTEG_W-1:0]   integ_ff;
   logic signed [prc_pkg::INTEG_W-1:0]   integ_in;
   logic signed [prc_pkg::DRIVE_W-1:0]   drive_ff;
   logic signed [prc_pkg::DRIVE_W-1:0]   drive_in;
   logic                                 sat_ff;
   logic                                 sat_in;
   logic signed [prc_pkg::ISUM_W-1:0]    isum;
   logic signed [prc_pkg::ISUM_W-1:0]    ilim;
   logic signed [prc_pkg::ISUM_W-1:0]    iclamp;
   logic signed [prc_pkg::DSUM_W-1:0]    dsum;
   logic signed [prc_pkg::DSUM_W-1:0]    olim;
   logic signed [prc_pkg::DSUM_W-1:0]    oclamp;

   assign in_ready = !valid_ff || rsp_ready;
   assign accept   = in_valid && in_ready;

   // integral: add, clamp only when strictly beyond the limit
   always_comb begin
      ilim = $signed({{(prc_pkg::ISUM_W - prc_pkg::GAIN_W){1'b0}}, cfg.max_integral});
      isum = prc_pkg::ISUM_W'(integ_ff) + in_data.i_term;
      if (isum > ilim) begin
         iclamp = ilim;
      end else if (isum < -ilim) begin
         iclamp = -ilim;
      end else begin
         iclamp = isum;
      end
      integ_in = prc_pkg::INTEG_W'(iclamp);
   end

   // output: exact sum of the three terms, then symmetric saturation
   always_comb begin
      olim = $signed({{(prc_pkg::DSUM_W - prc_pkg::GAIN_W){1'b0}}, cfg.max_output});
      dsum = prc_pkg::DSUM_W'(in_data.p_term) + prc_pkg::DSUM_W'(integ_in)
           + prc_pkg::DSUM_W'(in_data.d_term);
      sat_in = 1'b1;
      if (dsum > olim) begin
         oclamp = olim;
      end else if (dsum < -olim) begin
         oclamp = -olim;
      end else begin
         oclamp = dsum;
         sat_in = 1'b0;
      end
      drive_in = prc_pkg::DRIVE_W'(oclamp);
   end

   // control and integral state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         integ_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            integ_ff <= integ_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (accept) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_drive     = drive_ff;
   assign rsp_saturated = sat_ff;

   // integral stays inside the limit in force when it was updated
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (prc_pkg::ISUM_W'(integ_ff) <= $past(ilim)
                  && prc_pkg::ISUM_W'(integ_ff) >= -$past(ilim)))
      else $error("integral outside its clamp");

   // a saturated result sits exactly on one of the output limits
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (!sat_ff || prc_pkg::DSUM_W'(drive_ff) == $past(olim)
                  || prc_pkg::DSUM_W'(drive_ff) == -$past(olim)))
      else $error("saturated flag without drive at limit");

endmodule

`default_nettype wire

>>> src/pid_rate_controller.sv
// pid_rate_controller: top level, register file and the three pipeline stages
// depends on prc_pkg, prc_front, prc_mult, prc_accum
//
// Single-channel PID on angular rate, all values Q12.4.
// req channel: one item = measured_rate (tdata[15:0]) and target_rate
//   (tdata[31:16]), both signed. The error is measured minus target.
// rsp channel: one item per request, drive (tdata[16:0], signed, upper
//   bits zero) and saturated (tuser) when the output limit was applied.
// csr port: csr_wen writes csr_wdata into register csr_index at the clock
//   edge: 0 p_gain, 1 i_gain, 2 d_gain, 3 max_output, 4 max_integral;
//   other indexes are ignored. Write only while no item is in flight.
// Timing: three register stages (input/error, gain products, integral and
//   output sum). The input register takes the item at its accepting edge,
//   after which the product register and then the result register hold it.
//   One item per cycle is sustained while rsp_tready is high; the
//   integral update and clamp close their loop within the last stage.
// Stall: each stage holds its item while the next is full, so rsp_tready
//   low backs up the pipe and req_tready drops once all stages are full.
// Reset: empties the pipe, clears the integral and previous error and
//   loads the default gains and limits.

`default_nettype none

module pid_rate_controller (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // measured_rate [15:0], target_rate [31:16]
   input  wire logic [prc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // drive [16:0], zero fill above
   output logic [prc_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // saturated [0]
   output logic                                    rsp_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_wen,
   input  wire logic [prc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [prc_pkg::GAIN_W-1:0]         csr_wdata
);

   prc_pkg::cfg_type                     cfg_ff;
   prc_pkg::err_type                     err_data;
   prc_pkg::term_type                    term_data;
   logic                                 err_valid;
   logic                                 err_ready;
   logic                                 term_valid;
   logic                                 term_ready;
   logic signed [prc_pkg::DRIVE_W-1:0]   drive;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain       <= prc_pkg::RST_P_GAIN;
         cfg_ff.i_gain       <= prc_pkg::RST_I_GAIN;
         cfg_ff.d_gain       <= prc_pkg::RST_D_GAIN;
         cfg_ff.max_output   <= prc_pkg::RST_MAX_OUTPUT;
         cfg_ff.max_integral <= prc_pkg::RST_MAX_INTEGRAL;
      end else if (csr_wen) begin
         case (csr_index)
            prc_pkg::REG_P_GAIN: begin
               cfg_ff.p_gain <= csr_wdata;
            end
            prc_pkg::REG_I_GAIN: begin
               cfg_ff.i_gain <= csr_wdata;
            end
            prc_pkg::REG_D_GAIN: begin
               cfg_ff.d_gain <= csr_wdata;
            end
            prc_pkg::REG_MAX_OUTPUT: begin
               cfg_ff.max_output <= csr_wdata;
            end
            prc_pkg::REG_MAX_INTEGRAL: begin
               cfg_ff.max_integral <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // error stage
   prc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_valid  (err_valid),
      .out_ready  (err_ready),
      .out_data   (err_data)
   );

   // gain products
   prc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .in_data   (err_data),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_data  (term_data)
   );

   // integral, sum and saturation
   prc_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (term_valid),
      .in_ready      (term_ready),
      .in_data       (term_data),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_drive     (drive),
      .rsp_saturated (rsp_tuser)
   );

   assign rsp_tdata = {{(prc_pkg::RSP_DATA_W - prc_pkg::DRIVE_W){1'b0}}, drive};

endmodule

`default_nettype wire
